// ===== rtl/esort_pkg.sv =====
// esort_pkg: shared constants and types for the exchange sort engine.
// Used by esort_ram and exchange_sort_engine; no dependencies.
`default_nettype none

package esort_pkg;

    localparam int MAX_ITEMS = 64;                    // element store depth
    localparam int DATA_W    = 32;                    // element width
    localparam int IDX_W     = $clog2(MAX_ITEMS);     // store address width
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1); // fill count width

    // One write and one read access to the element store per cycle.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef enum logic [7:0] {
        ST_FILL  = 8'b0000_0001,  // taking input transfers
        ST_LOADI = 8'b0000_0010,  // read element i
        ST_LATCH = 8'b0000_0100,  // hold element i, read i+1
        ST_SCAN  = 8'b0000_1000,  // compare/swap one j per cycle
        ST_STORE = 8'b0001_0000,  // write back position i
        ST_OREAD = 8'b0010_0000,  // read first sorted element
        ST_OLOAD = 8'b0100_0000,  // load output register
        ST_OHOLD = 8'b1000_0000   // wait for output transfer
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/esort_ram.sv =====
// esort_ram: element store, one write port and one registered read port.
// Depends on esort_pkg.
`default_nettype none

module esort_ram (
    input  wire logic                         clk,
    input  wire esort_pkg::ram_req_t          req,
    output logic [esort_pkg::DATA_W-1:0]      rd_data
);

    logic [esort_pkg::DATA_W-1:0] mem [esort_pkg::MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/exchange_sort_engine.sv =====
// exchange_sort_engine: block sorter with one shared signed comparator.
// Depends on esort_pkg and esort_ram.
//
// The block collects signed 32-bit elements, one per input transfer, into a
// 64-entry store; the transfer with tlast closes the block. Elements beyond
// the store size are dropped and every result of that block carries
// m_axis_tuser = 1. The stored block is sorted ascending by exchange sort
// (each position i against every later j, swap when the later one is
// smaller) and then sent out one element per transfer, the final one with
// tlast. A block of a single stored element is not sorted. For n stored
// elements the sort makes n(n-1)/2 compares, one compare per cycle, all on
// the one shared comparator: the element at position i is held in a
// register and each later position is read once per pass from the single
// read port of the element store. Each result is read from the store only
// after the one before it has been taken. s_axis_tready is high only while
// a block is being collected; no input is taken during sort or output.
`default_nettype none

module exchange_sort_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [esort_pkg::DATA_W-1:0]  s_axis_tdata,  // [31:0] value
    input  wire logic                          s_axis_tlast,  // last
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [esort_pkg::DATA_W-1:0]       m_axis_tdata,  // [31:0] sorted_value
    output logic                               m_axis_tlast,  // end_of_block
    output logic                               m_axis_tuser   // [0] overflowed
);

    localparam int IDX_W = esort_pkg::IDX_W;
    localparam int CNT_W = esort_pkg::CNT_W;

    esort_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;     // elements stored / block size
    logic                drop_reg, drop_next;     // block had dropped elements
    logic [IDX_W-1:0]    i_reg, i_next;           // outer position
    logic [IDX_W-1:0]    j_reg, j_next;           // position whose data is on rd_data
    logic [IDX_W-1:0]    k_reg, k_next;           // output position
    logic [esort_pkg::DATA_W-1:0] cur_reg, cur_next;  // running element at i
    logic                out_valid_reg, out_valid_next;
    logic [esort_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                out_ovf_reg, out_ovf_next;

    esort_pkg::ram_req_t          ram_req;
    logic [esort_pkg::DATA_W-1:0] rd_data;
    logic [CNT_W-1:0]             fill_after;
    logic                         in_xfer;
    logic                         swap;

    esort_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign in_xfer    = s_axis_tvalid && (state_reg == esort_pkg::ST_FILL);
    assign fill_after = (fill_reg < CNT_W'(esort_pkg::MAX_ITEMS)) ?
                        fill_reg + CNT_W'(1) : fill_reg;
    // the later element is smaller: it takes position i
    assign swap       = $signed(rd_data) < $signed(cur_reg);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = i_reg;
        ram_req.wdata  = cur_reg;
        ram_req.raddr  = i_reg;

        unique case (state_reg)
            esort_pkg::ST_FILL:
            begin
                if (in_xfer)
                begin
                    if (fill_reg < CNT_W'(esort_pkg::MAX_ITEMS))
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = fill_reg[IDX_W-1:0];
                        ram_req.wdata = s_axis_tdata;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    fill_next = fill_after;
                    if (s_axis_tlast)
                    begin
                        i_next = '0;
                        k_next = '0;
                        // a single element needs no sorting
                        if (fill_after == CNT_W'(1))
                        begin
                            state_next = esort_pkg::ST_OREAD;
                        end
                        else
                        begin
                            state_next = esort_pkg::ST_LOADI;
                        end
                    end
                end
            end

            esort_pkg::ST_LOADI:
            begin
                ram_req.raddr = i_reg;
                state_next    = esort_pkg::ST_LATCH;
            end

            esort_pkg::ST_LATCH:
            begin
                cur_next      = rd_data;
                ram_req.raddr = i_reg + IDX_W'(1);
                j_next        = i_reg + IDX_W'(1);
                state_next    = esort_pkg::ST_SCAN;
            end

            esort_pkg::ST_SCAN:
            begin
                if (swap)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = j_reg;
                    ram_req.wdata = cur_reg;
                    cur_next      = rd_data;
                end
                if (({1'b0, j_reg} + CNT_W'(1)) < fill_reg)
                begin
                    ram_req.raddr = j_reg + IDX_W'(1);
                    j_next        = j_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = esort_pkg::ST_STORE;
                end
            end

            esort_pkg::ST_STORE:
            begin
                // write back position i, fetch i+1 for the next pass
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = cur_reg;
                ram_req.raddr = i_reg + IDX_W'(1);
                i_next        = i_reg + IDX_W'(1);
                if (({1'b0, i_reg} + CNT_W'(2)) < fill_reg)
                begin
                    state_next = esort_pkg::ST_LATCH;
                end
                else
                begin
                    state_next = esort_pkg::ST_OREAD;
                end
            end

            esort_pkg::ST_OREAD:
            begin
                ram_req.raddr = k_reg;
                state_next    = esort_pkg::ST_OLOAD;
            end

            esort_pkg::ST_OLOAD:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_data;
                out_last_next  = (({1'b0, k_reg} + CNT_W'(1)) == fill_reg);
                out_ovf_next   = drop_reg;
                state_next     = esort_pkg::ST_OHOLD;
            end

            esort_pkg::ST_OHOLD:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        fill_next  = '0;
                        drop_next  = 1'b0;
                        state_next = esort_pkg::ST_FILL;
                    end
                    else
                    begin
                        k_next        = k_reg + IDX_W'(1);
                        ram_req.raddr = k_reg + IDX_W'(1);
                        state_next    = esort_pkg::ST_OLOAD;
                    end
                end
            end

            default:
            begin
                out_valid_next = 1'b0;
                fill_next      = '0;
                drop_next      = 1'b0;
                state_next     = esort_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esort_pkg::ST_FILL;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign s_axis_tready = (state_reg == esort_pkg::ST_FILL);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/esort_checker.sv =====
// esort_checker: port-level assertions for exchange_sort_engine, plus bind.
// Depends on esort_pkg.
`default_nettype none

module esort_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [esort_pkg::DATA_W-1:0]  m_axis_tdata,
    input  wire logic                          m_axis_tlast,
    input  wire logic                          m_axis_tuser
);

    // collection and output never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // closing input transfer stops intake until the block is out
    a_close_block: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after block close");

    // after the final result goes out, no further result follows at once
    a_end_block: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("result after end of block");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
         && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind exchange_sort_engine esort_checker u_esort_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for exchange_sort_engine.
// Needs esort_pkg and the engine RTL. It drives blocks of signed elements and
// checks every sorted transfer against an in-bench block sorter or a typed-in result.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Slowest correct run: a handful of 64+ element blocks, each sorted on the
    // one shared comparator, plus output under an 83% receiver stall. The
    // limit is taken well above that.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 250;

    // One expected result: field order follows the result stream.
    typedef struct packed {
        logic [esort_pkg::DATA_W-1:0] value;
        logic                         end_of_block;
        logic                         overflowed;
    } sorted_t;

    // Directed row. Rows with has_want carry their result typed in.
    typedef struct packed {
        logic [esort_pkg::DATA_W-1:0] value;
        logic                         last;
        logic                         has_want;
        logic [esort_pkg::DATA_W-1:0] want_value;
        logic                         want_end;
        logic                         want_ovf;
    } script_row_t;

    localparam int SCRIPT_LEN = 21;

    // Single-element blocks at the extremes have an obvious result; the rest
    // (mixed signs, duplicates, sorted and reversed input) go to the sorter.
    script_row_t script [SCRIPT_LEN] = '{
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0005, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0003, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hAAAA_5555, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{32'hAAAA_5555, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [esort_pkg::DATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
    logic                         s_axis_tlast = 1'b0; // last
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [esort_pkg::DATA_W-1:0] m_axis_tdata;        // [31:0] sorted_value
    logic                         m_axis_tlast;        // end_of_block
    logic                         m_axis_tuser;        // [0] overflowed

    // Sorter state: the open block as the engine should hold it.
    logic signed [esort_pkg::DATA_W-1:0] open_block [$];
    logic                                open_dropped = 1'b0;
    sorted_t                             pending_sorted [$];

    int sender_idle_pct   = 28;
    int receiver_idle_pct = 83;
    int mismatch_count    = 0;
    int results_checked   = 0;
    int elements_sent     = 0;
    int blocks_sent       = 0;
    int cut_blocks        = 0;
    int cycles            = 0;

    exchange_sort_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, pending_sorted.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Takes one accepted element. Stores it, or drops it when the store is
    // full; on last, sorts the stored part by exchange sort and returns one
    // result per stored element.
    function automatic void take_element(input logic [esort_pkg::DATA_W-1:0] value,
                                         input logic last,
                                         output sorted_t run [$]);
        logic signed [esort_pkg::DATA_W-1:0] held [$];
        logic signed [esort_pkg::DATA_W-1:0] swap;
        sorted_t                             item;
        run = {};
        if (open_block.size() < esort_pkg::MAX_ITEMS)
            open_block.push_back(value);
        else
            open_dropped = 1'b1;
        if (last)
        begin
            held = open_block;
            for (int i = 0; i < held.size(); i++)
                for (int j = i + 1; j < held.size(); j++)
                    if (held[j] < held[i])
                    begin
                        swap    = held[j];
                        held[j] = held[i];
                        held[i] = swap;
                    end
            for (int k = 0; k < held.size(); k++)
            begin
                item.value        = held[k];
                item.end_of_block = (k == held.size() - 1);
                item.overflowed   = open_dropped;
                run.push_back(item);
            end
            open_block   = {};
            open_dropped = 1'b0;
        end
    endfunction

    // One input transfer. A random gap may come first; tvalid stays high
    // between back-to-back elements.
    task automatic send_element(input logic [esort_pkg::DATA_W-1:0] value,
                                input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        elements_sent++;
    endtask

    // Element values: full-range noise, a narrow band that yields many
    // duplicates, and the extremes.
    function automatic logic [esort_pkg::DATA_W-1:0] pick_value();
        logic [esort_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            3: v = $urandom_range(0, 8) - 4;
            4:
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_results(input sorted_t run [$]);
        foreach (run[k])
            pending_sorted.push_back(run[k]);
        if (run.size() != 0)
        begin
            blocks_sent++;
            if (run[0].overflowed)
                cut_blocks++;
        end
    endtask

    // Result side: random stalls, and each transfer is checked against the
    // oldest expected result.
    always @(posedge clk)
    begin
        sorted_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (pending_sorted.size() == 0)
                flag_mismatch($sformatf("result %h with nothing expected", m_axis_tdata));
            else
            begin
                want = pending_sorted.pop_front();
                if (m_axis_tdata !== want.value)
                    flag_mismatch($sformatf("sorted_value %h, expected %h",
                                            m_axis_tdata, want.value));
                if (m_axis_tlast !== want.end_of_block)
                    flag_mismatch($sformatf("end_of_block %b, expected %b on %h",
                                            m_axis_tlast, want.end_of_block, want.value));
                if (m_axis_tuser !== want.overflowed)
                    flag_mismatch($sformatf("overflowed %b, expected %b on %h",
                                            m_axis_tuser, want.overflowed, want.value));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    initial
    begin
        sorted_t                      run [$];
        sorted_t                      typed;
        logic [esort_pkg::DATA_W-1:0] v;
        int                           blk;
        int                           len;
        int                           rand_items;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part; idling phase one (sender 28%, receiver 83%).
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            send_element(script[r].value, script[r].last);
            take_element(script[r].value, script[r].last, run);
            if (script[r].has_want)
            begin
                typed.value        = script[r].want_value;
                typed.end_of_block = script[r].want_end;
                typed.overflowed   = script[r].want_ovf;
                run = {typed};
            end
            queue_results(run);
        end

        // Random blocks. Most are short; three fixed slots hit the store
        // size exactly, one past it (last element dropped) and further past.
        blk        = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS || blk <= 18)
        begin
            if (blk == 4)
                len = esort_pkg::MAX_ITEMS;
            else if (blk == 11)
                len = esort_pkg::MAX_ITEMS + 1;
            else if (blk == 18)
                len = $urandom_range(esort_pkg::MAX_ITEMS + 2, esort_pkg::MAX_ITEMS + 8);
            else
                len = $urandom_range(1, 6);

            for (int k = 0; k < len; k++)
            begin
                // swap idling sides after a third, then run flat out
                if (rand_items < RANDOM_ITEMS / 3)
                begin
                    sender_idle_pct   = 28;
                    receiver_idle_pct = 83;
                end
                else if (rand_items < 2 * RANDOM_ITEMS / 3)
                begin
                    sender_idle_pct   = 83;
                    receiver_idle_pct = 28;
                end
                else
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
                v = pick_value();
                send_element(v, k == len - 1);
                take_element(v, k == len - 1, run);
                queue_results(run);
                rand_items++;
            end
            blk++;
        end
        s_axis_tvalid <= 1'b0;

        // Let the last block finish, then watch for stray results.
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d elements in %0d blocks, %0d of them cut at the store size",
                 elements_sent, blocks_sent, cut_blocks);
        $display("summary: %0d sorted transfers checked, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_sorted.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/esort_pkg.sv
rtl/esort_ram.sv
rtl/exchange_sort_engine.sv
rtl/esort_checker.sv
bench/testbench.sv
